// ===== sv/mm4_pkg.sv =====
// Package for the 4x4 fixed-point matrix multiplier: sizes, token and write types.
// Used by mm4_cell, mm4_scale and matrix_multiply_4x4; depends on nothing.
`timescale 1ns / 1ps

package mm4_pkg;

    localparam int DIM       = 4;
    localparam int FRAC_BITS = 16;
    localparam int IDX_W     = (DIM > 1) ? $clog2(DIM) : 1;
    localparam int ELEM_W    = 32;
    localparam int PROD_W    = 2 * ELEM_W;
    localparam int ACC_W     = PROD_W + $clog2(DIM);

    localparam logic [ELEM_W-1:0] SAT_MAX = {1'b0, {(ELEM_W-1){1'b1}}};
    localparam logic [ELEM_W-1:0] SAT_MIN = {1'b1, {(ELEM_W-1){1'b0}}};

    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic             last;
    } tok_t;

    typedef struct packed {
        logic              left_en;
        logic              right_en;
        logic [IDX_W-1:0]  addr;
        logic [ELEM_W-1:0] data;
    } cell_wr_t;

endpackage

// ===== sv/mm4_cell.sv =====
// One multiply-accumulate cell of the chain: holds one column of the left matrix
// and one row of the right matrix. Depends on mm4_pkg.
`timescale 1ns / 1ps

module mm4_cell (
    input  logic                           clk,
    input  logic                           rst_n,
    input  mm4_pkg::cell_wr_t              wr,
    input  mm4_pkg::tok_t                  tok_in,
    input  logic signed [mm4_pkg::ACC_W-1:0] sum_in,
    output mm4_pkg::tok_t                  tok_out,
    output logic signed [mm4_pkg::ACC_W-1:0] sum_out
);
    import mm4_pkg::*;

    logic signed [ELEM_W-1:0] left_col_reg  [DIM];
    logic signed [ELEM_W-1:0] right_row_reg [DIM];

    tok_t                     tok_a_reg;
    tok_t                     tok_b_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [ACC_W-1:0]  sum_a_reg;
    logic signed [ACC_W-1:0]  sum_b_reg;
    logic signed [ACC_W-1:0]  sum_b_next;

    always_ff @(posedge clk)
    begin
        if (wr.left_en)
        begin
            left_col_reg[wr.addr] <= wr.data;
        end
        if (wr.right_en)
        begin
            right_row_reg[wr.addr] <= wr.data;
        end
    end

    assign prod_next  = left_col_reg[tok_in.row] * right_row_reg[tok_in.col];
    assign sum_b_next = sum_a_reg + {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_a_reg <= '0;
            tok_b_reg <= '0;
        end
        else
        begin
            tok_a_reg <= tok_in;
            tok_b_reg <= tok_a_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg  <= prod_next;
        sum_a_reg <= sum_in;
        sum_b_reg <= sum_b_next;
    end

    assign tok_out = tok_b_reg;
    assign sum_out = sum_b_reg;

endmodule

// ===== sv/mm4_scale.sv =====
// Output stage: drops the fraction bits of a finished dot product and saturates it.
// Depends on mm4_pkg.
`timescale 1ns / 1ps

module mm4_scale (
    input  logic                             clk,
    input  logic                             rst_n,
    input  mm4_pkg::tok_t                    tok_in,
    input  logic signed [mm4_pkg::ACC_W-1:0] sum_in,
    output logic                             strobe,
    output logic signed [mm4_pkg::ELEM_W-1:0] product_value,
    output logic [1:0]                       out_row,
    output logic [1:0]                       out_col,
    output logic                             saturated,
    output logic                             last
);
    import mm4_pkg::*;

    logic signed [ACC_W-1:0]      shifted;
    logic [ACC_W-ELEM_W:0]        upper;
    logic                         fits;
    logic [ELEM_W-1:0]            value_next;
    logic [IDX_W+1:0]             row_ext;
    logic [IDX_W+1:0]             col_ext;

    logic                         strobe_reg;
    logic [ELEM_W-1:0]            value_reg;
    logic [1:0]                   row_reg;
    logic [1:0]                   col_reg;
    logic                         sat_reg;
    logic                         last_reg;

    always_comb
    begin
        shifted = sum_in >>> FRAC_BITS;
        upper   = shifted[ACC_W-1:ELEM_W-1];
        fits    = (upper == '0) || (upper == '1);
        if (fits)
        begin
            value_next = shifted[ELEM_W-1:0];
        end
        else if (sum_in[ACC_W-1])
        begin
            value_next = SAT_MIN;
        end
        else
        begin
            value_next = SAT_MAX;
        end
        row_ext = {2'b00, tok_in.row};
        col_ext = {2'b00, tok_in.col};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= tok_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        row_reg   <= row_ext[1:0];
        col_reg   <= col_ext[1:0];
        sat_reg   <= !fits;
        last_reg  <= tok_in.last;
    end

    assign strobe        = strobe_reg;
    assign product_value = value_reg;
    assign out_row       = row_reg;
    assign out_col       = col_reg;
    assign saturated     = sat_reg;
    assign last          = last_reg && strobe_reg;

endmodule

// ===== sv/matrix_multiply_4x4.sv =====
// Top level of the 4x4 Q16.16 matrix multiplier: element loader, result sequencer,
// the chain of mm4_cell instances and the mm4_scale output stage. Depends on mm4_pkg.
//
//  Channel   Handshake        Payload
//  request   start, busy      value_in, restart
//  result    strobe           product_value, out_row, out_col, saturated, last
//
// One element is taken per cycle while busy is low; restart puts an element at the
// first position of the left matrix. Taking the last element of the right matrix
// raises busy. Results then come one per cycle in row-major order, and busy stays
// high until the result flagged last has been strobed.
// The receiver cannot stall: each result is shown for one cycle with strobe.
// Reset clears the load position, the sequencer and the pipeline valid bits.
`timescale 1ns / 1ps

module matrix_multiply_4x4 (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic signed [mm4_pkg::ELEM_W-1:0] value_in,
    input  logic                              restart,
    output logic                              strobe,
    output logic signed [mm4_pkg::ELEM_W-1:0] product_value,
    output logic [1:0]                        out_row,
    output logic [1:0]                        out_col,
    output logic                              saturated,
    output logic                              last
);
    import mm4_pkg::*;

    localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(DIM - 1);

    logic             take;
    logic             pos_right;
    logic [IDX_W-1:0] pos_row;
    logic [IDX_W-1:0] pos_col;
    logic             trigger;

    logic             ld_right_reg, ld_right_next;
    logic [IDX_W-1:0] ld_row_reg, ld_row_next;
    logic [IDX_W-1:0] ld_col_reg, ld_col_next;

    logic             busy_reg, busy_next;
    logic             issuing_reg, issuing_next;
    logic [IDX_W-1:0] iss_row_reg, iss_row_next;
    logic [IDX_W-1:0] iss_col_reg, iss_col_next;

    tok_t                    issue_tok;
    tok_t                    chain_tok [DIM+1];
    logic signed [ACC_W-1:0] chain_sum [DIM+1];
    cell_wr_t                cell_wr   [DIM];

    assign take      = start && !busy_reg;
    assign pos_right = restart ? 1'b0 : ld_right_reg;
    assign pos_row   = restart ? '0 : ld_row_reg;
    assign pos_col   = restart ? '0 : ld_col_reg;
    assign trigger   = take && pos_right && (pos_row == IDX_MAX) && (pos_col == IDX_MAX);

    always_comb
    begin
        ld_right_next = ld_right_reg;
        ld_row_next   = ld_row_reg;
        ld_col_next   = ld_col_reg;
        if (take)
        begin
            ld_right_next = pos_right;
            ld_row_next   = pos_row;
            ld_col_next   = pos_col + 1'b1;
            if (pos_col == IDX_MAX)
            begin
                ld_col_next = '0;
                ld_row_next = pos_row + 1'b1;
                if (pos_row == IDX_MAX)
                begin
                    ld_row_next   = '0;
                    ld_right_next = !pos_right;
                end
            end
        end
    end

    always_comb
    begin
        for (int k = 0; k < DIM; k++)
        begin
            cell_wr[k].left_en  = take && !pos_right && (pos_col == IDX_W'(k));
            cell_wr[k].right_en = take && pos_right && (pos_row == IDX_W'(k));
            cell_wr[k].addr     = pos_right ? pos_col : pos_row;
            cell_wr[k].data     = value_in;
        end
    end

    always_comb
    begin
        busy_next    = busy_reg;
        issuing_next = issuing_reg;
        iss_row_next = iss_row_reg;
        iss_col_next = iss_col_reg;
        if (trigger)
        begin
            busy_next    = 1'b1;
            issuing_next = 1'b1;
            iss_row_next = '0;
            iss_col_next = '0;
        end
        else
        begin
            if (issuing_reg)
            begin
                iss_col_next = iss_col_reg + 1'b1;
                if (iss_col_reg == IDX_MAX)
                begin
                    iss_col_next = '0;
                    iss_row_next = iss_row_reg + 1'b1;
                    if (iss_row_reg == IDX_MAX)
                    begin
                        iss_row_next = '0;
                        issuing_next = 1'b0;
                    end
                end
            end
            if (strobe && last)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ld_right_reg <= 1'b0;
            ld_row_reg   <= '0;
            ld_col_reg   <= '0;
            busy_reg     <= 1'b0;
            issuing_reg  <= 1'b0;
            iss_row_reg  <= '0;
            iss_col_reg  <= '0;
        end
        else
        begin
            ld_right_reg <= ld_right_next;
            ld_row_reg   <= ld_row_next;
            ld_col_reg   <= ld_col_next;
            busy_reg     <= busy_next;
            issuing_reg  <= issuing_next;
            iss_row_reg  <= iss_row_next;
            iss_col_reg  <= iss_col_next;
        end
    end

    always_comb
    begin
        issue_tok.valid = issuing_reg;
        issue_tok.row   = iss_row_reg;
        issue_tok.col   = iss_col_reg;
        issue_tok.last  = (iss_row_reg == IDX_MAX) && (iss_col_reg == IDX_MAX);
    end

    assign chain_tok[0] = issue_tok;
    assign chain_sum[0] = '0;

    for (genvar k = 0; k < DIM; k++)
    begin : g_cell
        mm4_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .wr      (cell_wr[k]),
            .tok_in  (chain_tok[k]),
            .sum_in  (chain_sum[k]),
            .tok_out (chain_tok[k+1]),
            .sum_out (chain_sum[k+1])
        );
    end

    mm4_scale u_scale (
        .clk           (clk),
        .rst_n         (rst_n),
        .tok_in        (chain_tok[DIM]),
        .sum_in        (chain_sum[DIM]),
        .strobe        (strobe),
        .product_value (product_value),
        .out_row       (out_row),
        .out_col       (out_col),
        .saturated     (saturated),
        .last          (last)
    );

    assign busy = busy_reg;

endmodule

// ===== bench/matrix_multiply_4x4_tb.sv =====
// Self-checking testbench for matrix_multiply_4x4: streams Q16.16 matrix pairs with restarts
// and random gaps, predicts every product element and checks each strobed result in order.
// Depends on mm4_pkg and matrix_multiply_4x4.
`timescale 1ns / 1ps

module matrix_multiply_4x4_tb;

    import mm4_pkg::*;

    localparam int NELEM = DIM * DIM;
    localparam int TARGET_REQUESTS = 450;

    typedef enum int {
        FILL_WIDE,
        FILL_NARROW,
        FILL_EDGE,
        FILL_MAX,
        FILL_MIN,
        FILL_DIAG
    } fill_kind_t;

    typedef struct packed {
        logic signed [ELEM_W-1:0] value;
        logic [1:0]               row;
        logic [1:0]               col;
        logic                     sat;
        logic                     last;
    } product_t;

    class product_tracker;
        logic signed [ELEM_W-1:0] left_elems[NELEM];
        logic signed [ELEM_W-1:0] right_elems[NELEM];
        int                       loaded = 0;
        product_t                 pending[$];
        int                       mismatches = 0;

        task report_mismatch(string msg);
            if (mismatches < 100)
            begin
                $display("%0t: mismatch: %s", $time, msg);
            end
            mismatches++;
        endtask

        function void take_element(logic signed [ELEM_W-1:0] v, logic rs);
            product_t                 p;
            logic signed [127:0]      acc;
            logic signed [127:0]      scaled;
            logic signed [PROD_W-1:0] term;
            if (rs)
            begin
                loaded = 0;
            end
            if (loaded < NELEM)
            begin
                left_elems[loaded] = v;
            end
            else
            begin
                right_elems[loaded - NELEM] = v;
            end
            loaded++;
            if (loaded == 2 * NELEM)
            begin
                loaded = 0;
                for (int r = 0; r < DIM; r++)
                begin
                    for (int c = 0; c < DIM; c++)
                    begin
                        acc = '0;
                        for (int k = 0; k < DIM; k++)
                        begin
                            term = left_elems[r * DIM + k] * right_elems[k * DIM + c];
                            acc = acc + term;
                        end
                        scaled = acc >>> FRAC_BITS;
                        if (scaled[127:31] == '0 || scaled[127:31] == '1)
                        begin
                            p.value = scaled[ELEM_W-1:0];
                            p.sat = 1'b0;
                        end
                        else
                        begin
                            p.value = scaled[127] ? SAT_MIN : SAT_MAX;
                            p.sat = 1'b1;
                        end
                        p.row = 2'(r);
                        p.col = 2'(c);
                        p.last = (r == DIM - 1) && (c == DIM - 1);
                        pending.push_back(p);
                    end
                end
            end
        endfunction

        task check_product(logic signed [ELEM_W-1:0] value, logic [1:0] row, logic [1:0] col,
                           logic sat, logic last_flag);
            product_t want;
            if (pending.size() == 0)
            begin
                report_mismatch($sformatf("unexpected product %h at (%0d,%0d)", value, row, col));
            end
            else
            begin
                want = pending.pop_front();
                if (value !== want.value)
                    report_mismatch($sformatf("(%0d,%0d) value %h, want %h",
                                              want.row, want.col, value, want.value));
                if (row !== want.row)
                    report_mismatch($sformatf("row %0d, want %0d", row, want.row));
                if (col !== want.col)
                    report_mismatch($sformatf("col %0d, want %0d", col, want.col));
                if (sat !== want.sat)
                    report_mismatch($sformatf("(%0d,%0d) saturated %b, want %b",
                                              want.row, want.col, sat, want.sat));
                if (last_flag !== want.last)
                    report_mismatch($sformatf("(%0d,%0d) last %b, want %b",
                                              want.row, want.col, last_flag, want.last));
            end
        endtask

        task close_out();
            while (pending.size() != 0)
            begin
                void'(pending.pop_front());
                report_mismatch("expected product never arrived");
            end
        endtask
    endclass

    logic                     clk;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    logic signed [ELEM_W-1:0] value_in;
    logic                     restart;
    logic                     strobe;
    logic signed [ELEM_W-1:0] product_value;
    logic [1:0]               out_row;
    logic [1:0]               out_col;
    logic                     saturated;
    logic                     last;

    product_tracker tracker = new();
    int             requests_sent = 0;

    matrix_multiply_4x4 i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .value_in      (value_in),
        .restart       (restart),
        .strobe        (strobe),
        .product_value (product_value),
        .out_row       (out_row),
        .out_col       (out_col),
        .saturated     (saturated),
        .last          (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("matrix_multiply_4x4 test failed");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && strobe)
        begin
            tracker.check_product(product_value, out_row, out_col, saturated, last);
        end
    end

    function automatic int pick_gap(bit dense);
        int roll;
        roll = $urandom_range(0, 99);
        if (dense || roll < 60)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    function automatic logic [ELEM_W-1:0] pick_value(fill_kind_t kind, int idx);
        case (kind)
            FILL_NARROW: return ELEM_W'($urandom_range(0, 524288)) - 32'd262144;
            FILL_EDGE:
            begin
                case ($urandom_range(0, 5))
                    0: return SAT_MAX;
                    1: return SAT_MIN;
                    2: return '0;
                    3: return '1;
                    4: return 32'h0001_0000;
                    default: return $urandom;
                endcase
            end
            FILL_MAX: return SAT_MAX;
            FILL_MIN: return SAT_MIN;
            FILL_DIAG: return (idx / DIM == idx % DIM) ? 32'h0001_0000 : 32'h0;
            default: return $urandom;
        endcase
    endfunction

    task automatic pause_requests(int cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            start <= 1'b0;
            value_in <= $urandom;
            restart <= 1'($urandom_range(0, 1));
        end
    endtask

    task automatic send_element(logic signed [ELEM_W-1:0] v, logic rs, bit dense);
        @(negedge clk);
        start <= 1'b1;
        value_in <= v;
        restart <= rs;
        do
            @(posedge clk);
        while (busy);
        tracker.take_element(v, rs);
        requests_sent++;
        pause_requests(pick_gap(dense));
    endtask

    task automatic send_matrices(fill_kind_t left_kind, fill_kind_t right_kind, logic first_rs,
                                 int count, bit dense);
        for (int i = 0; i < count; i++)
        begin
            if (i < NELEM)
                send_element(pick_value(left_kind, i), (i == 0) ? first_rs : 1'b0, dense);
            else
                send_element(pick_value(right_kind, i - NELEM), 1'b0, dense);
        end
    endtask

    initial
    begin
        int waited;
        fill_kind_t lk;
        fill_kind_t rk;
        rst_n = 1'b0;
        start = 1'b0;
        value_in = '0;
        restart = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_matrices(FILL_EDGE, FILL_EDGE, 1'b0, 3, 1'b0);
        send_matrices(FILL_MAX, FILL_MAX, 1'b1, 2 * NELEM, 1'b1);
        send_matrices(FILL_MAX, FILL_MIN, 1'b0, 2 * NELEM, 1'b0);
        send_matrices(FILL_DIAG, FILL_MAX, 1'b1, 2 * NELEM, 1'b0);
        send_matrices(FILL_DIAG, FILL_MIN, 1'b1, 2 * NELEM - 1, 1'b1);
        send_matrices(FILL_MIN, FILL_MIN, 1'b1, 2 * NELEM, 1'b0);

        while (requests_sent < TARGET_REQUESTS)
        begin
            lk = fill_kind_t'($urandom_range(FILL_WIDE, FILL_DIAG));
            rk = fill_kind_t'($urandom_range(FILL_WIDE, FILL_DIAG));
            send_matrices(lk, rk, 1'($urandom_range(0, 1)),
                          ($urandom_range(0, 99) < 85) ? 2 * NELEM : $urandom_range(1, 2 * NELEM - 1),
                          $urandom_range(0, 2) == 0);
        end

        @(negedge clk);
        start <= 1'b0;
        waited = 0;
        while (tracker.pending.size() != 0 && waited < 1000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (2 * DIM + 4) @(posedge clk);
        tracker.close_out();
        if (tracker.mismatches == 0)
            $display("matrix_multiply_4x4 test passed");
        else
            $display("matrix_multiply_4x4 test failed");
        $finish;
    end

endmodule
